/* hdl/tbmd_pkg.sv */
`default_nettype none

package tbmd_pkg;

    // field widths
    localparam int SUBJ_W = 16;
    localparam int TIME_W = 32;
    localparam int GLU_W  = 14;
    localparam int LEN_W  = 17;
    localparam int END_W  = 33;
    localparam int CNT_W  = 10;
    localparam int SUM_W  = 24;

    // defaults
    localparam int               MAX_COUNT_DEF = 1023;
    localparam logic [LEN_W-1:0] LEN_RESET     = LEN_W'(900);
    localparam int               QUEUE_DEPTH   = 2;

    // request kind after classification
    typedef enum logic {
        KIND_SAMPLE,
        KIND_FLUSH
    } t_kind;

    // one queued request
    typedef struct packed {
        t_kind              kind;
        logic [SUBJ_W-1:0]  subject;
        logic [TIME_W-1:0]  stime;
        logic [GLU_W-1:0]   glucose;
    } t_entry;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  dividend;
        logic [LEN_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [TIME_W-1:0]  quotient;
    } t_div_rsp;

    // back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX_START,
        ST_IDX_WAIT,
        ST_DECIDE,
        ST_MEAN_START,
        ST_MEAN_WAIT,
        ST_MUL,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* hdl/tbmd_front.sv */
`default_nettype none

module tbmd_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_cmd,
    input  wire logic [15:0]     i_subject_tag,
    input  wire logic [31:0]     i_sample_time,
    input  wire logic [13:0]     i_glucose_value,
    input  wire logic            i_value_missing,
    output logic                 o_q_valid,
    output tbmd_pkg::t_entry     o_q_entry,
    input  wire logic            i_q_pop
);

    localparam int PTR_W = $clog2(tbmd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tbmd_pkg::QUEUE_DEPTH + 1);

    tbmd_pkg::t_entry r_mem [tbmd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             accept;
    logic             push;
    tbmd_pkg::t_entry new_entry;

    // classify: flush goes through, missing readings are dropped here
    always_comb begin
        accept            = i_in_valid && o_in_ready;
        push              = accept && (i_cmd || !i_value_missing);
        new_entry.kind    = i_cmd ? tbmd_pkg::KIND_FLUSH : tbmd_pkg::KIND_SAMPLE;
        new_entry.subject = i_subject_tag;
        new_entry.stime   = i_sample_time;
        new_entry.glucose = i_glucose_value;
    end

    // queue pointers
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(tbmd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(tbmd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_q_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!push && i_q_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_entry;
        end
    end

    assign o_in_ready = (r_fill != CNT_W'(tbmd_pkg::QUEUE_DEPTH));
    assign o_q_valid  = (r_fill != '0);
    assign o_q_entry  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

/* hdl/tbmd_div.sv */
`default_nettype none

module tbmd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tbmd_pkg::t_div_req i_req,
    output tbmd_pkg::t_div_rsp      o_rsp
);

    localparam int DW = tbmd_pkg::TIME_W;
    localparam int VW = tbmd_pkg::LEN_W;
    localparam int IW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [IW-1:0] r_cnt;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   rem_sh;
    logic [VW+1:0] diff;
    logic          ge;
    logic [VW-1:0] rem_nxt;

    // one restoring step per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[DW-1]};
        diff    = {1'b0, rem_sh} - {2'b00, r_div};
        ge      = !diff[VW+1];
        rem_nxt = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= rem_nxt;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

/* hdl/tbmd_back.sv */
`default_nettype none

module tbmd_back #(
    parameter int MAX_COUNT = tbmd_pkg::MAX_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [16:0]          i_bin_len,
    input  wire logic                 i_q_valid,
    input  wire tbmd_pkg::t_entry     i_q_entry,
    output logic                      o_q_pop,
    output tbmd_pkg::t_div_req        o_div_req,
    input  wire tbmd_pkg::t_div_rsp   i_div_rsp,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [15:0]               o_out_subject,
    output logic [32:0]               o_bin_end_time,
    output logic [13:0]               o_mean_glucose,
    output logic [9:0]                o_sample_count
);

    localparam int CW      = tbmd_pkg::CNT_W;
    localparam int SW      = tbmd_pkg::SUM_W;
    localparam int CNT_TOP = (1 << CW) - 1;
    localparam logic [CW-1:0] COUNT_CAP = CW'((MAX_COUNT > CNT_TOP) ? CNT_TOP : MAX_COUNT);
    localparam int MUL_W   = tbmd_pkg::END_W + tbmd_pkg::LEN_W;

    tbmd_pkg::t_state r_state, n_state;
    tbmd_pkg::t_entry r_cur;
    logic [tbmd_pkg::TIME_W-1:0] r_idx;
    logic [tbmd_pkg::GLU_W-1:0]  r_mean;
    logic [tbmd_pkg::END_W-1:0]  r_end;

    // open bin
    logic                         r_open_valid;
    logic [tbmd_pkg::SUBJ_W-1:0]  r_open_subject;
    logic [tbmd_pkg::TIME_W-1:0]  r_open_idx;
    logic [SW-1:0]                r_sum;
    logic [CW-1:0]                r_count;

    // output register
    logic                         r_out_valid;
    logic [tbmd_pkg::SUBJ_W-1:0]  r_out_subject;
    logic [tbmd_pkg::END_W-1:0]   r_out_end;
    logic [tbmd_pkg::GLU_W-1:0]   r_out_mean;
    logic [CW-1:0]                r_out_count;

    logic             match;
    logic             emit_ok;
    logic [SW:0]      sum_add;
    logic [SW-1:0]    sum_sat;
    logic [MUL_W-1:0] product;

    // datapath helpers
    always_comb begin
        match   = r_open_valid && (r_cur.subject == r_open_subject) && (r_idx == r_open_idx);
        sum_add = {1'b0, r_sum} + (SW + 1)'(r_cur.glucose);
        sum_sat = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
        product = MUL_W'({1'b0, r_open_idx} + 33'd1) * MUL_W'(i_bin_len);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tbmd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_entry.kind == tbmd_pkg::KIND_FLUSH) begin
                        n_state = r_open_valid ? tbmd_pkg::ST_MEAN_START : tbmd_pkg::ST_IDLE;
                    end else begin
                        n_state = tbmd_pkg::ST_IDX_START;
                    end
                end
            end
            tbmd_pkg::ST_IDX_START: n_state = tbmd_pkg::ST_IDX_WAIT;
            tbmd_pkg::ST_IDX_WAIT: begin
                if (i_div_rsp.done) n_state = tbmd_pkg::ST_DECIDE;
            end
            tbmd_pkg::ST_DECIDE: begin
                if (!match && r_open_valid) n_state = tbmd_pkg::ST_MEAN_START;
                else                        n_state = tbmd_pkg::ST_IDLE;
            end
            tbmd_pkg::ST_MEAN_START: n_state = tbmd_pkg::ST_MEAN_WAIT;
            tbmd_pkg::ST_MEAN_WAIT: begin
                if (i_div_rsp.done) n_state = tbmd_pkg::ST_MUL;
            end
            tbmd_pkg::ST_MUL: n_state = tbmd_pkg::ST_EMIT;
            tbmd_pkg::ST_EMIT: begin
                if (emit_ok) n_state = tbmd_pkg::ST_IDLE;
            end
            default: n_state = tbmd_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_q_pop            = (r_state == tbmd_pkg::ST_IDLE) && i_q_valid;
        o_div_req.start    = (r_state == tbmd_pkg::ST_IDX_START) ||
                             (r_state == tbmd_pkg::ST_MEAN_START);
        o_div_req.dividend = r_cur.stime;
        o_div_req.divisor  = i_bin_len;
        if (r_state == tbmd_pkg::ST_MEAN_START) begin
            o_div_req.dividend = tbmd_pkg::TIME_W'(r_sum);
            o_div_req.divisor  = tbmd_pkg::LEN_W'(r_count);
        end
        emit_ok = (r_state == tbmd_pkg::ST_EMIT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tbmd_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_cur <= i_q_entry;
        if (r_state == tbmd_pkg::ST_IDX_WAIT && i_div_rsp.done) begin
            r_idx <= i_div_rsp.quotient;
        end
        if (r_state == tbmd_pkg::ST_MEAN_WAIT && i_div_rsp.done) begin
            r_mean <= i_div_rsp.quotient[tbmd_pkg::GLU_W-1:0];
        end
        if (r_state == tbmd_pkg::ST_MUL) r_end <= product[tbmd_pkg::END_W-1:0];
    end

    // open bin update, close and reopen
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_valid   <= 1'b0;
            r_open_subject <= '0;
            r_open_idx     <= '0;
            r_sum          <= '0;
            r_count        <= '0;
        end else if (r_state == tbmd_pkg::ST_DECIDE && match) begin
            if (r_count < COUNT_CAP) begin
                r_sum   <= sum_sat;
                r_count <= r_count + 1'b1;
            end
        end else if ((r_state == tbmd_pkg::ST_DECIDE && !r_open_valid) ||
                     (emit_ok && r_cur.kind == tbmd_pkg::KIND_SAMPLE)) begin
            r_open_valid   <= 1'b1;
            r_open_subject <= r_cur.subject;
            r_open_idx     <= r_idx;
            r_sum          <= SW'(r_cur.glucose);
            r_count        <= CW'(1);
        end else if (emit_ok) begin
            r_open_valid <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_ok) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ok) begin
            r_out_subject <= r_open_subject;
            r_out_end     <= r_end;
            r_out_mean    <= r_mean;
            r_out_count   <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_subject  = r_out_subject;
    assign o_bin_end_time = r_out_end;
    assign o_mean_glucose = r_out_mean;
    assign o_sample_count = r_out_count;

endmodule

`default_nettype wire

/* hdl/time_bin_mean_downsampler.sv */
// Averages time-stamped glucose samples into clock-aligned bins of
// bin_seconds (register, 0 acts as 1) per subject and emits one result per
// closed bin: subject, bin end time, truncated mean and count. A bin closes
// when a sample of another subject or bin arrives, or on a flush request.
// Missing readings are dropped at the input. A two-entry queue sits
// between the input and the bin sequencer. The sequencer shares one
// radix-2 divider (32 steps): a sample uses it to find its bin index; a
// sample that closes the open bin adds the mean division and the end-time
// multiply, and a flush that closes a bin needs only those two.
// Write bin_seconds only while the block is idle.
`default_nettype none

module time_bin_mean_downsampler #(
    parameter int MAX_COUNT = tbmd_pkg::MAX_COUNT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [16:0] i_cfg_bin_seconds,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_cmd,
    input  wire logic [15:0] i_subject_tag,
    input  wire logic [31:0] i_sample_time,
    input  wire logic [13:0] i_glucose_value,
    input  wire logic        i_value_missing,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_out_subject,
    output logic [32:0]      o_bin_end_time,
    output logic [13:0]      o_mean_glucose,
    output logic [9:0]       o_sample_count
);

    logic [16:0]        r_bin_seconds;
    logic [16:0]        bin_len;
    logic               q_valid;
    logic               q_pop;
    tbmd_pkg::t_entry   q_entry;
    tbmd_pkg::t_div_req div_req;
    tbmd_pkg::t_div_rsp div_rsp;

    // bin length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_seconds <= tbmd_pkg::LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bin_seconds <= i_cfg_bin_seconds;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign bin_len     = (r_bin_seconds == '0) ? 17'd1 : r_bin_seconds;

    tbmd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_subject_tag   (i_subject_tag),
        .i_sample_time   (i_sample_time),
        .i_glucose_value (i_glucose_value),
        .i_value_missing (i_value_missing),
        .o_q_valid       (q_valid),
        .o_q_entry       (q_entry),
        .i_q_pop         (q_pop)
    );

    tbmd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tbmd_back #(
        .MAX_COUNT (MAX_COUNT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bin_len      (bin_len),
        .i_q_valid      (q_valid),
        .i_q_entry      (q_entry),
        .o_q_pop        (q_pop),
        .o_div_req      (div_req),
        .i_div_rsp      (div_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_subject  (o_out_subject),
        .o_bin_end_time (o_bin_end_time),
        .o_mean_glucose (o_mean_glucose),
        .o_sample_count (o_sample_count)
    );

endmodule

`default_nettype wire

/* hdl/tbmd_checker.sv */
`default_nettype none

module tbmd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_out_subject,
    input wire logic [32:0] o_bin_end_time,
    input wire logic [13:0] o_mean_glucose,
    input wire logic [9:0]  o_sample_count
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a closed bin always holds at least one reading
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample_count != 10'd0))
        else $error("result with zero count");

    // stalled result stays
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_subject) && $stable(o_bin_end_time) &&
            $stable(o_mean_glucose) && $stable(o_sample_count))
        else $error("result payload changed while stalled");

endmodule

bind time_bin_mean_downsampler tbmd_checker u_checker (.*);

`default_nettype wire

/* verif/time_bin_mean_downsampler_tb.sv */
// bin count stops here, never above what the count field can hold
localparam int COUNT_CAP = (tbmd_pkg::MAX_COUNT_DEF > 1023) ? 1023
                                                            : tbmd_pkg::MAX_COUNT_DEF;
localparam logic [tbmd_pkg::SUM_W-1:0] SUM_MAX = '1;

typedef struct packed {
    tbmd_pkg::t_kind                kind;
    logic [tbmd_pkg::SUBJ_W-1:0]    subject;
    logic [tbmd_pkg::TIME_W-1:0]    stime;
    logic [tbmd_pkg::GLU_W-1:0]     glucose;
    logic                           missing;
} t_sample_req;

typedef struct packed {
    logic [tbmd_pkg::SUBJ_W-1:0]    subject;
    logic [tbmd_pkg::END_W-1:0]     end_time;
    logic [tbmd_pkg::GLU_W-1:0]     mean;
    logic [tbmd_pkg::CNT_W-1:0]     count;
} t_bin_result;

// tracks the open bin and the closed bins still owed by the block
class bin_mean_scoreboard;
    logic [tbmd_pkg::LEN_W-1:0]     bin_len;
    bit                             open_valid;
    logic [tbmd_pkg::SUBJ_W-1:0]    open_subj;
    logic [tbmd_pkg::TIME_W-1:0]    open_idx;
    logic [tbmd_pkg::SUM_W-1:0]     run_sum;
    logic [tbmd_pkg::CNT_W-1:0]     run_cnt;
    t_bin_result                    closed_bins[$];
    int                             bad_count;

    function new();
        bin_len    = tbmd_pkg::LEN_RESET;
        open_valid = 0;
        open_subj  = '0;
        open_idx   = '0;
        run_sum    = '0;
        run_cnt    = '0;
        bad_count  = 0;
    endfunction

    function logic [31:0] eff_len();
        return (bin_len == 0) ? 32'd1 : 32'(bin_len);
    endfunction

    // end time uses the length in force when the bin closes
    function t_bin_result close_bin();
        logic [63:0] end_full;
        t_bin_result res;
        end_full     = (64'(open_idx) + 64'd1) * 64'(eff_len());
        res.subject  = open_subj;
        res.end_time = end_full[tbmd_pkg::END_W-1:0];
        res.mean     = (tbmd_pkg::GLU_W)'(run_sum / (tbmd_pkg::SUM_W)'(run_cnt));
        res.count    = run_cnt;
        return res;
    endfunction

    function void take_request(t_sample_req r);
        logic [tbmd_pkg::TIME_W-1:0] idx;
        logic [tbmd_pkg::SUM_W:0]    acc;
        // flush closes whatever is open, other fields ignored
        if (r.kind == tbmd_pkg::KIND_FLUSH) begin
            if (open_valid)
                closed_bins = {closed_bins, close_bin()};
            open_valid = 0;
            return;
        end
        if (r.missing)
            return;
        idx = r.stime / eff_len();
        // same subject and bin: accumulate until the count caps
        if (open_valid && r.subject == open_subj && idx == open_idx) begin
            if (run_cnt < COUNT_CAP) begin
                acc     = {1'b0, run_sum} + (tbmd_pkg::SUM_W + 1)'(r.glucose);
                run_sum = (acc > {1'b0, SUM_MAX}) ? SUM_MAX : acc[tbmd_pkg::SUM_W-1:0];
                run_cnt = run_cnt + 1'b1;
            end
            return;
        end
        if (open_valid)
            closed_bins = {closed_bins, close_bin()};
        open_valid = 1;
        open_subj  = r.subject;
        open_idx   = idx;
        run_sum    = (tbmd_pkg::SUM_W)'(r.glucose);
        run_cnt    = (tbmd_pkg::CNT_W)'(1);
    endfunction

    function void check_bin(t_bin_result got);
        t_bin_result want;
        if (closed_bins.size() == 0) begin
            bad_count++;
            if (bad_count <= 10)
                $display("unexpected bin result: subject %0d end %0d mean %0d count %0d",
                         got.subject, got.end_time, got.mean, got.count);
            return;
        end
        want = closed_bins.pop_front();
        if (got.subject !== want.subject || got.end_time !== want.end_time ||
            got.mean !== want.mean || got.count !== want.count) begin
            bad_count++;
            if (bad_count <= 10)
                $display({"bin result mismatch (expected/actual): subject %0d/%0d ",
                          "end %0d/%0d mean %0d/%0d count %0d/%0d"},
                         want.subject, got.subject, want.end_time, got.end_time,
                         want.mean, got.mean, want.count, got.count);
        end
    endfunction
endclass

module time_bin_mean_downsampler_tb;

    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam longint RUN_LIMIT = 64'd6_000_000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [tbmd_pkg::LEN_W-1:0]     i_cfg_bin_seconds;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_cmd;
    logic [tbmd_pkg::SUBJ_W-1:0]    i_subject_tag;
    logic [tbmd_pkg::TIME_W-1:0]    i_sample_time;
    logic [tbmd_pkg::GLU_W-1:0]     i_glucose_value;
    logic                           i_value_missing;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [tbmd_pkg::SUBJ_W-1:0]    o_out_subject;
    logic [tbmd_pkg::END_W-1:0]     o_bin_end_time;
    logic [tbmd_pkg::GLU_W-1:0]     o_mean_glucose;
    logic [tbmd_pkg::CNT_W-1:0]     o_sample_count;

    bit calm_mode    = 0;
    bit hold_request = 0;

    bin_mean_scoreboard sb = new();

    time_bin_mean_downsampler DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_bin_seconds (i_cfg_bin_seconds),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_subject_tag     (i_subject_tag),
        .i_sample_time     (i_sample_time),
        .i_glucose_value   (i_glucose_value),
        .i_value_missing   (i_value_missing),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_subject     (o_out_subject),
        .o_bin_end_time    (o_bin_end_time),
        .o_mean_glucose    (o_mean_glucose),
        .o_sample_count    (o_sample_count)
    );

    always #4 i_clk = ~i_clk;

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    function automatic t_sample_req make_req(tbmd_pkg::t_kind kind,
                                             logic [tbmd_pkg::SUBJ_W-1:0] subj,
                                             logic [tbmd_pkg::TIME_W-1:0] st,
                                             logic [tbmd_pkg::GLU_W-1:0] glu,
                                             logic miss);
        t_sample_req r;
        r.kind    = kind;
        r.subject = subj;
        r.stime   = st;
        r.glucose = glu;
        r.missing = miss;
        return r;
    endfunction

    // results first, then the request that may add to the expectations
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_bin(t_bin_result'{o_out_subject, o_bin_end_time,
                                           o_mean_glucose, o_sample_count});
            if (i_in_valid && o_in_ready)
                sb.take_request(make_req(tbmd_pkg::t_kind'(i_cmd), i_subject_tag,
                                         i_sample_time, i_glucose_value,
                                         i_value_missing));
            if (i_cfg_valid && o_cfg_ready)
                sb.bin_len = i_cfg_bin_seconds;
        end
    end

    // result side: random stalls, or a long counted hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_request = 0;
            end else begin
                i_out_ready <= calm_mode || ($urandom_range(99) >= 23);
            end
        end
    end

    // called at a falling edge; leaves valid high so the next request can follow
    task automatic send_request(input t_sample_req r);
        while (!calm_mode && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= r.kind;
        i_subject_tag   <= r.subject;
        i_sample_time   <= r.stime;
        i_glucose_value <= r.glucose;
        i_value_missing <= r.missing;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.closed_bins.size() != 0) @(negedge i_clk);
    endtask

    // quiet point: no bin owed and the sequencer given time to finish
    task automatic wait_settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_length(input logic [tbmd_pkg::LEN_W-1:0] len);
        i_cfg_valid       <= 1'b1;
        i_cfg_bin_seconds <= len;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [tbmd_pkg::GLU_W-1:0] pick_glucose();
        return ($urandom_range(9) == 0) ? (tbmd_pkg::GLU_W)'($urandom)
                                        : (tbmd_pkg::GLU_W)'($urandom_range(0, 10000));
    endfunction

    // mostly in-order runs per subject, with switches, flushes, gaps and noise
    task automatic run_traffic(input int unsigned n_items);
        logic [tbmd_pkg::SUBJ_W-1:0] subj;
        logic [tbmd_pkg::SUBJ_W-1:0] prev_subj;
        logic [tbmd_pkg::SUBJ_W-1:0] swap;
        logic [tbmd_pkg::TIME_W-1:0] t;
        int unsigned                 len;
        int unsigned                 sent;
        int unsigned                 pick;
        t_sample_req                 r;
        subj      = (tbmd_pkg::SUBJ_W)'($urandom);
        prev_subj = (tbmd_pkg::SUBJ_W)'($urandom);
        t         = $urandom;
        len       = sb.eff_len();
        sent      = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                t = t + $urandom_range(0, len / 2 + 1);
                r = make_req(tbmd_pkg::KIND_SAMPLE, subj, t, pick_glucose(), 1'b0);
            end else if (pick < 76) begin
                // new subject or a return to the previous one
                if ($urandom_range(1) == 0) begin
                    swap      = subj;
                    subj      = prev_subj;
                    prev_subj = swap;
                end else begin
                    prev_subj = subj;
                    subj      = (tbmd_pkg::SUBJ_W)'($urandom);
                end
                t = $urandom;
                r = make_req(tbmd_pkg::KIND_SAMPLE, subj, t, pick_glucose(), 1'b0);
            end else if (pick < 83) begin
                r = make_req(tbmd_pkg::KIND_SAMPLE, (tbmd_pkg::SUBJ_W)'($urandom), $urandom,
                             (tbmd_pkg::GLU_W)'($urandom), 1'b1);
            end else if (pick < 88) begin
                r = make_req(tbmd_pkg::KIND_FLUSH, (tbmd_pkg::SUBJ_W)'($urandom), $urandom,
                             (tbmd_pkg::GLU_W)'($urandom), 1'($urandom));
            end else if (pick < 93) begin
                // time going backwards
                t = t - $urandom_range(1, len * 3);
                r = make_req(tbmd_pkg::KIND_SAMPLE, subj, t, pick_glucose(), 1'b0);
            end else begin
                r = make_req(tbmd_pkg::KIND_SAMPLE, (tbmd_pkg::SUBJ_W)'($urandom), $urandom,
                             (tbmd_pkg::GLU_W)'($urandom), 1'b0);
            end
            send_request(r);
            sent++;
        end
    endtask

    // main stimulus
    initial begin
        logic [tbmd_pkg::LEN_W-1:0] phase_len[8];
        i_rst_n           = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_bin_seconds = '0;
        i_in_valid        = 1'b0;
        i_cmd             = 1'b0;
        i_subject_tag     = '0;
        i_sample_time     = '0;
        i_glucose_value   = '0;
        i_value_missing   = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, reset bin length
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'h1234, 32'hFFFF_0000, 14'h3FFF, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd7, 32'd5, 14'd100, 1'b1));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd0, 32'd0, 14'd0, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd0, 32'd899, 14'd10000, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd0, 32'd899, 14'd16383, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd0, 32'd900, 14'd1, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd0, 32'd5000, 14'd77, 1'b1));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'hFFFF, 32'd900, 14'd5, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, 14'd10000,
                              1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'hFFFF, 32'd100, 14'd42, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'h00FF, 32'h0F0F_0F0F, 14'h1555, 1'b1));
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'd0, 32'd0, 14'd0, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd1, 32'd1000, 14'd123, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd2, 32'd1000, 14'd456, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd1, 32'd1000, 14'd789, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'd0, 32'd0, 14'd0, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'h5555, 32'hAAAA_AAAA, 14'h2AAA, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'hAAAA, 32'h5555_5555, 14'h1555, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'd0, 32'd0, 14'd0, 1'b0));
        // length changed with a bin open: bin keeps its index
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd3, 32'd1799, 14'd50, 1'b0));
        wait_settle();
        write_length((tbmd_pkg::LEN_W)'(1000));
        send_request(make_req(tbmd_pkg::KIND_SAMPLE, 16'd3, 32'd1999, 14'd60, 1'b0));
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'd0, 32'd0, 14'd0, 1'b0));

        // random phases over several bin lengths
        phase_len = '{(tbmd_pkg::LEN_W)'(1), (tbmd_pkg::LEN_W)'(0), (tbmd_pkg::LEN_W)'(60),
                      (tbmd_pkg::LEN_W)'(86400), (tbmd_pkg::LEN_W)'(131071),
                      (tbmd_pkg::LEN_W)'(900),
                      (tbmd_pkg::LEN_W)'($urandom_range(1, 86400)),
                      (tbmd_pkg::LEN_W)'($urandom)};
        for (int p = 0; p < 8; p++) begin
            wait_settle();
            write_length(phase_len[p]);
            calm_mode = (p == 2);
            if (p == 0 || p == 5)
                hold_request = 1;
            if (p == 3) begin
                run_traffic(50);
                wait_results();
                run_traffic(50);
            end else begin
                run_traffic(100);
            end
        end
        calm_mode = 0;
        send_request(make_req(tbmd_pkg::KIND_FLUSH, 16'd0, 32'd0, 14'd0, 1'b0));

        wait_settle();
        if (sb.bad_count == 0 && sb.closed_bins.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
